@@ rtl/core/psswa_pkg.sv @@
package psswa_pkg;

    // table and window sizing
    localparam int SLOTS  = 4;
    localparam int WINDOW = 10;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W = $clog2(SLOTS + 1);

    // field widths
    localparam int ADDR_W  = 64;
    localparam int VAL_W   = 16;
    localparam int CNT_W   = 16;
    localparam int SUM_W   = 32;
    localparam int NCH     = 3;
    localparam int CH_W    = 2;
    localparam int IDX_W   = 2;
    localparam int SUM_MEM_W = NCH * SUM_W;

    // stream widths
    localparam int IN_W    = 2 * ADDR_W + NCH * VAL_W + CNT_W;
    localparam int OUT_RAW = IDX_W + NCH * SUM_W;
    localparam int OUT_W   = 8 * ((OUT_RAW + 7) / 8);
    localparam int USER_W  = 2;

    localparam logic [CH_W-1:0] CH_LAST = CH_W'(NCH - 1);

    // reciprocal of WINDOW for the sum divide: q_est = (|s| * DIV_M) >> DIV_SHIFT,
    // off by at most one low, fixed by a remainder compare
    localparam int DIV_SHIFT  = 31;
    localparam int DIV_PROD_W = 63;
    localparam logic [31:0] DIV_M = 32'((64'd1 << DIV_SHIFT) / WINDOW);
    localparam int DIV_REM_W  = 41;

    // reciprocal of WINDOW for the count modulo
    localparam int CNT_SHIFT  = 16;
    localparam int CNT_PROD_W = 33;
    localparam logic [16:0] CNT_M = 17'((64'd1 << CNT_SHIFT) / WINDOW);
    localparam int CNT_REM_W  = 25;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_ADD,
        ST_MUL,
        ST_FIX,
        ST_OUT
    } state_t;

endpackage

@@ rtl/core/per_sender_sensor_window_averager_top.sv @@
// Channel  Dir  Signals                          Content
// -------  ---  -------------------------------  ---------------------------------------
// s_axis   in   tvalid/tready/tdata[191:0]       one sensor report
// m_axis   out  tvalid/tready/tdata[103:0],tuser one result transaction per report
//
// Per report the sequencer steps ST_IDLE, ST_LOOK, then ST_OUT when dropped (table
// full, new sender), else ST_ADD for the sum memory read-modify-write and, when a
// window closes, ST_MUL and ST_FIX per channel on one reciprocal multiplier shared
// by the three channels, before ST_OUT.
// Reset (rst_n, async, active low) clears slot valid bits, fill count, the
// sequencer and the output valid; sum memory content is ignored until a slot is
// claimed. A stalled output holds its transaction while the next report is taken
// and processed; the sequencer waits only when it must load a still-full output.
module per_sender_sensor_window_averager_top
    import psswa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // sender_addr_hi[63:0], sender_addr_lo[127:64], light_value[143:128],
    // temp_value[159:144], hum_value[175:160], report_count[191:176]
    input  logic [IN_W-1:0]   s_axis_tdata,

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // slot_index[1:0], light_mean[33:2], temp_mean[65:34], hum_mean[97:66], zero pad
    output logic [OUT_W-1:0]  m_axis_tdata,
    // avg_valid[0], dropped[1]
    output logic [USER_W-1:0] m_axis_tuser
);

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    state_t state_reg, state_next;

    // captured report
    logic [ADDR_W-1:0]       hi_reg, lo_reg;
    logic signed [VAL_W-1:0] val_reg [NCH];
    logic [CNT_W-1:0]        cnt_reg;

    // sender address table, gated by per-slot valid bits
    logic [ADDR_W-1:0]       tbl_hi_reg [SLOTS];
    logic [ADDR_W-1:0]       tbl_lo_reg [SLOTS];
    logic [SLOTS-1:0]        slot_valid_reg;
    logic [FILL_W-1:0]       fill_reg;

    // running sums: one entry per slot, {hum, temp, light}
    logic [SUM_MEM_W-1:0]    sum_mem [SLOTS];
    logic [SUM_MEM_W-1:0]    sum_rd_reg;

    logic [SLOT_W-1:0]       slot_reg;
    logic                    new_reg;
    logic                    drop_reg;
    logic                    closed_reg;
    logic [CNT_PROD_W-1:0]   cnt_prod_reg;

    // divide loop
    logic signed [SUM_W-1:0] sum_reg [NCH];
    logic [CH_W-1:0]         ch_reg;
    logic [DIV_PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0] avg_reg [NCH];

    // output register
    logic                    out_valid_reg;
    logic [OUT_W-1:0]        out_data_reg;
    logic [USER_W-1:0]       out_user_reg;

    // ---------------------------------------------------------------
    // combinational
    // ---------------------------------------------------------------
    logic                    in_acc;
    logic                    out_load;
    logic                    mem_we;
    logic                    tbl_we;

    logic                    hit;
    logic [SLOT_W-1:0]       hit_slot;
    logic                    full;
    logic [SLOT_W-1:0]       look_slot;
    logic                    look_drop;

    logic signed [SUM_W-1:0] old_sum [NCH];
    logic signed [SUM_W-1:0] new_sum [NCH];
    logic [SUM_MEM_W-1:0]    mem_wdata;

    logic [CNT_W-1:0]        cnt_q;
    logic [CNT_REM_W-1:0]    cnt_rem;
    logic                    closed_c;

    logic [SUM_W-1:0]        abs_val;
    logic [SUM_W-1:0]        q_est;
    logic [DIV_REM_W-1:0]    div_rem;
    logic [SUM_W-1:0]        q_fix;
    logic [SUM_W-1:0]        avg_c;

    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [OUT_W-1:0]        out_data_c;
    logic [USER_W-1:0]       out_user_c;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
        if (s[SUM_W] != s[SUM_W-1])
        begin
            sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sat_add = s[SUM_W-1:0];
        end
    endfunction

    // sender lookup: all slots compared at once, lowest match wins
    always_comb
    begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int k = SLOTS - 1; k >= 0; k--)
        begin
            if (slot_valid_reg[k] && tbl_hi_reg[k] == hi_reg && tbl_lo_reg[k] == lo_reg)
            begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(k);
            end
        end
    end

    assign full      = (fill_reg == FILL_W'(SLOTS));
    assign look_slot = hit ? hit_slot : fill_reg[SLOT_W-1:0];
    assign look_drop = !hit && full;

    // saturating accumulate; a freshly claimed slot starts from zero, and a closing window writes back zero
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            old_sum[c] = new_reg ? '0 : sum_rd_reg[c*SUM_W +: SUM_W];
            new_sum[c] = sat_add(old_sum[c], val_reg[c]);
            mem_wdata[c*SUM_W +: SUM_W] = closed_c ? '0 : new_sum[c];
        end
    end

    // report_count mod WINDOW: reciprocal estimate, remainder lands in [0, 2*WINDOW)
    assign cnt_q    = cnt_prod_reg[CNT_SHIFT +: CNT_W];
    assign cnt_rem  = CNT_REM_W'(cnt_reg) - CNT_REM_W'(cnt_q) * CNT_REM_W'(WINDOW);
    assign closed_c = (cnt_rem == '0) || (cnt_rem == CNT_REM_W'(WINDOW));

    // signed sum / WINDOW, truncated toward zero, one channel at a time
    assign abs_val = sum_reg[ch_reg][SUM_W-1] ? (~sum_reg[ch_reg] + 32'd1) : sum_reg[ch_reg];
    assign q_est   = prod_reg[DIV_SHIFT +: SUM_W];
    assign div_rem = DIV_REM_W'(abs_val) - DIV_REM_W'(q_est) * DIV_REM_W'(WINDOW);
    assign q_fix   = (div_rem >= DIV_REM_W'(WINDOW)) ? (q_est + 32'd1) : q_est;
    assign avg_c   = sum_reg[ch_reg][SUM_W-1] ? (~q_fix + 32'd1) : q_fix;

    // result packing
    assign slot_ext = {{IDX_W{1'b0}}, slot_reg};
    always_comb
    begin
        out_data_c = '0;
        if (!drop_reg)
        begin
            out_data_c[IDX_W-1:0] = slot_ext[IDX_W-1:0];
        end
        if (closed_reg)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                out_data_c[IDX_W + c*SUM_W +: SUM_W] = avg_reg[c];
            end
        end
        out_user_c = {drop_reg, closed_reg};
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: state_next = look_drop ? ST_OUT : ST_ADD;
            ST_ADD:  state_next = closed_c ? ST_MUL : ST_OUT;
            ST_MUL:  state_next = ST_FIX;
            ST_FIX:  state_next = (ch_reg == CH_LAST) ? ST_OUT : ST_MUL;
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        in_acc        = s_axis_tvalid && (state_reg == ST_IDLE);
        out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);
        mem_we        = (state_reg == ST_ADD);
        tbl_we        = (state_reg == ST_LOOK) && !hit && !full;
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= '0;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (tbl_we)
            begin
                slot_valid_reg[look_slot] <= 1'b1;
                fill_reg                  <= fill_reg + FILL_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            hi_reg     <= s_axis_tdata[0 +: ADDR_W];
            lo_reg     <= s_axis_tdata[ADDR_W +: ADDR_W];
            val_reg[0] <= s_axis_tdata[2*ADDR_W +: VAL_W];
            val_reg[1] <= s_axis_tdata[2*ADDR_W + VAL_W +: VAL_W];
            val_reg[2] <= s_axis_tdata[2*ADDR_W + 2*VAL_W +: VAL_W];
            cnt_reg    <= s_axis_tdata[2*ADDR_W + 3*VAL_W +: CNT_W];
        end

        if (state_reg == ST_LOOK)
        begin
            slot_reg     <= look_slot;
            new_reg      <= !hit;
            drop_reg     <= look_drop;
            closed_reg   <= 1'b0;
            cnt_prod_reg <= CNT_PROD_W'(cnt_reg) * CNT_PROD_W'(CNT_M);
        end

        if (tbl_we)
        begin
            tbl_hi_reg[look_slot] <= hi_reg;
            tbl_lo_reg[look_slot] <= lo_reg;
        end

        if (state_reg == ST_ADD)
        begin
            closed_reg <= closed_c;
            ch_reg     <= '0;
            for (int c = 0; c < NCH; c++)
            begin
                sum_reg[c] <= new_sum[c];
            end
        end

        if (state_reg == ST_MUL)
        begin
            prod_reg <= DIV_PROD_W'(abs_val) * DIV_PROD_W'(DIV_M);
        end

        if (state_reg == ST_FIX)
        begin
            avg_reg[ch_reg] <= avg_c;
            ch_reg          <= ch_reg + CH_W'(1);
        end

        if (out_load)
        begin
            out_data_reg <= out_data_c;
            out_user_reg <= out_user_c;
        end
    end

    // sum memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sum_mem[slot_reg] <= mem_wdata;
        end
        sum_rd_reg <= sum_mem[look_slot];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

@@ test/tb_per_sender_sensor_window_averager_top.sv @@
`timescale 1ns / 100ps

module tb_per_sender_sensor_window_averager_top;
    import psswa_pkg::*;

    localparam int     CLK_HALF     = 6;
    localparam int     RESET_CYCLES = 9;
    localparam int     LONG_HOLD    = 80;      // receiver hold-off, in cycles
    localparam int     SAT_REPORTS  = 12;      // extreme readings on one sender
    localparam int     TAIL_CYCLES  = 20;
    localparam longint CYCLE_LIMIT  = 4_000_000;
    localparam longint SUM_HI       = 2147483647;
    localparam longint SUM_LO       = -SUM_HI - 1;

    // tuser bit positions
    localparam int UB_AVG  = 0;
    localparam int UB_DROP = 1;

    typedef struct packed {
        logic [ADDR_W-1:0]       hi;
        logic [ADDR_W-1:0]       lo;
        logic signed [VAL_W-1:0] light;
        logic signed [VAL_W-1:0] temp;
        logic signed [VAL_W-1:0] hum;
        logic [CNT_W-1:0]        count;
    } report_t;

    typedef struct packed {
        logic [IDX_W-1:0]        slot;
        logic                    avg_valid;
        logic                    dropped;
        logic signed [SUM_W-1:0] light;
        logic signed [SUM_W-1:0] temp;
        logic signed [SUM_W-1:0] hum;
    } avg_result_t;

    logic              clk;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic [USER_W-1:0] m_axis_tuser;

    per_sender_sensor_window_averager_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // stimulus and scoreboard
    report_t     pending_reports[$];
    avg_result_t expected_avgs[$];
    report_t     on_bus;
    logic        in_fire     = 1'b0;
    bit          quiet       = 1'b0;   // no idling on either side
    bit          long_hold_go = 1'b0;
    int          hold_count  = 0;
    int          send_gap    = 0;
    int          recv_gap    = 0;
    int          mismatches  = 0;
    longint      cycle_count = 0;

    // predictor state: sender table, sums and fill count
    logic [ADDR_W-1:0] seen_hi [SLOTS];
    logic [ADDR_W-1:0] seen_lo [SLOTS];
    bit                seen_used [SLOTS] = '{default: 1'b0};
    longint            light_acc [SLOTS] = '{default: 0};
    longint            temp_acc  [SLOTS] = '{default: 0};
    longint            hum_acc   [SLOTS] = '{default: 0};
    int                slots_taken = 0;

    // senders that own table slots
    logic [ADDR_W-1:0] known_hi [4];
    logic [ADDR_W-1:0] known_lo [4];

    function automatic longint sat_sum(input longint acc, input logic signed [VAL_W-1:0] v);
        longint s;
        s = acc + longint'(v);
        if (s > SUM_HI)
            return SUM_HI;
        if (s < SUM_LO)
            return SUM_LO;
        return s;
    endfunction

    function automatic avg_result_t predict_window_avg(input report_t r);
        avg_result_t res;
        int          hit;
        int          k;
        res = '0;
        hit = -1;
        for (k = 0; k < SLOTS; k++)
            if (hit < 0 && seen_used[k] && seen_hi[k] == r.hi && seen_lo[k] == r.lo)
                hit = k;
        if (hit < 0) begin
            // new sender on a full table: report is ignored
            if (slots_taken >= SLOTS) begin
                res.dropped = 1'b1;
                return res;
            end
            hit = slots_taken;
            seen_hi[hit]   = r.hi;
            seen_lo[hit]   = r.lo;
            seen_used[hit] = 1'b1;
            slots_taken++;
        end
        light_acc[hit] = sat_sum(light_acc[hit], r.light);
        temp_acc[hit]  = sat_sum(temp_acc[hit], r.temp);
        hum_acc[hit]   = sat_sum(hum_acc[hit], r.hum);
        res.slot = IDX_W'(hit);
        if (r.count % WINDOW == 0) begin
            // signed divide truncates toward zero
            res.avg_valid  = 1'b1;
            res.light      = SUM_W'(light_acc[hit] / WINDOW);
            res.temp       = SUM_W'(temp_acc[hit] / WINDOW);
            res.hum        = SUM_W'(hum_acc[hit] / WINDOW);
            light_acc[hit] = 0;
            temp_acc[hit]  = 0;
            hum_acc[hit]   = 0;
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic add_report(input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] lo,
                              input int light, input int temp, input int hum,
                              input int count);
        report_t r;
        r.hi    = hi;
        r.lo    = lo;
        r.light = VAL_W'(light);
        r.temp  = VAL_W'(temp);
        r.hum   = VAL_W'(hum);
        r.count = CNT_W'(count);
        pending_reports.push_back(r);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_reading();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return -16'sd1;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        if ($urandom_range(0, 2) == 0)
            return CNT_W'($urandom_range(0, 6553) * WINDOW);
        return CNT_W'($urandom);
    endfunction

    // mostly known senders; the rest are near misses and fresh addresses (dropped)
    task automatic queue_random_reports(input int n);
        report_t r;
        int      pick;
        int      k;
        int      b;
        repeat (n) begin
            pick = $urandom_range(0, 9);
            k    = $urandom_range(0, 3);
            if (pick < 8) begin
                r.hi = known_hi[k];
                r.lo = known_lo[k];
            end else if (pick == 8) begin
                b = $urandom_range(0, 2 * ADDR_W - 1);
                {r.lo, r.hi} = {known_lo[k], known_hi[k]} ^ (128'd1 << b);
            end else begin
                r.hi = {$urandom, $urandom};
                r.lo = {$urandom, $urandom};
            end
            r.light = pick_reading();
            r.temp  = pick_reading();
            r.hum   = pick_reading();
            r.count = pick_count();
            pending_reports.push_back(r);
        end
    endtask

    task automatic wait_all_done();
        while (pending_reports.size() != 0 || s_axis_tvalid || expected_avgs.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** per_sender_sensor_window_averager_top: FAILED **");
            $finish;
        end
    end

    // sender: offers one report per transaction, random gaps between them
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_reports.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (!quiet && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 5);
                s_axis_tvalid <= 1'b0;
            end else begin
                on_bus = pending_reports.pop_front();
                s_axis_tdata  <= {on_bus.count, on_bus.hum, on_bus.temp, on_bus.light,
                                  on_bus.lo, on_bus.hi};
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off when armed
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (long_hold_go && hold_count < LONG_HOLD) begin
            hold_count++;
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end else
            m_axis_tready <= 1'b1;
    end

    // result check against the oldest expectation, then predict the newly taken report
    always @(posedge clk)
    begin
        avg_result_t want;
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_avgs.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result transaction: expected none, actual %h/%h",
                         $time, m_axis_tuser, m_axis_tdata);
            end else begin
                want = expected_avgs.pop_front();
                check_field("slot_index", want.slot, m_axis_tdata[IDX_W-1:0]);
                check_field("avg_valid", want.avg_valid, m_axis_tuser[UB_AVG]);
                check_field("dropped", want.dropped, m_axis_tuser[UB_DROP]);
                check_field("light_mean", want.light,
                            $signed(m_axis_tdata[IDX_W +: SUM_W]));
                check_field("temp_mean", want.temp,
                            $signed(m_axis_tdata[IDX_W + SUM_W +: SUM_W]));
                check_field("hum_mean", want.hum,
                            $signed(m_axis_tdata[IDX_W + 2 * SUM_W +: SUM_W]));
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_avgs.push_back(predict_window_avg(on_bus));
    end

    initial
    begin
        int i;
        known_hi[0] = '0;                         known_lo[0] = '0;
        known_hi[1] = '1;                         known_lo[1] = '1;
        known_hi[2] = 64'h8000_0000_0000_0000;    known_lo[2] = 64'h1;
        known_hi[3] = {$urandom, $urandom};       known_lo[3] = {$urandom, $urandom};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: zero address on an empty table, extremes, truncation of negative sums
        add_report(known_hi[0], known_lo[0], 32767, -32768, 0, 1);
        add_report(known_hi[0], known_lo[0], -32768, 32767, -15, 0);
        add_report(known_hi[1], known_lo[1], -32768, -32768, -32768, 65535);
        add_report(known_hi[1], known_lo[1], 32767, 32767, 32767, 65530);
        add_report(known_hi[2], known_lo[2], 123, -456, 789, 10);
        add_report(known_hi[3], known_lo[3], -7, 19, 25, 3);
        add_report(known_hi[3], known_lo[3], -20, 1, 4, 40);
        // table now full: new senders are dropped, even when the count closes a window
        add_report(64'h0, 64'h1, 11, 22, 33, 7);
        add_report(64'h8000_0000_0000_0000, 64'h0, -1, -1, -1, 20);
        add_report('1, ~64'h1, 500, 600, 700, 5);
        add_report(known_hi[0], known_lo[0], 5, 5, 5, 9);
        add_report(known_hi[2], known_lo[2], 32767, 32767, 32767, 11);
        add_report(known_hi[2], known_lo[2], -32768, -32768, -32768, 12);
        add_report(known_hi[0], known_lo[0], 1, -1, 0, 20);
        wait_all_done();

        // random with an early long receiver hold-off so the input backs up
        long_hold_go = 1'b1;
        queue_random_reports(200);
        wait_all_done();

        // back-to-back extreme readings on one sender, then close its window
        quiet = 1'b1;
        add_report(known_hi[2], known_lo[2], 0, 0, 0, 30);
        for (i = 0; i < SAT_REPORTS; i++)
            add_report(known_hi[2], known_lo[2], 32767, -32768,
                       (i < SAT_REPORTS - 3) ? 32767 : -32768,
                       $urandom_range(0, 6552) * WINDOW + $urandom_range(1, WINDOW - 1));
        add_report(known_hi[2], known_lo[2], 32767, -1, 0, 50);
        wait_all_done();
        quiet = 1'b0;

        queue_random_reports(120);
        wait_all_done();

        // closing stretch with no idling
        quiet = 1'b1;
        queue_random_reports(100);
        wait_all_done();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_avgs.size() == 0)
            $display("** per_sender_sensor_window_averager_top: PASSED **");
        else
            $display("** per_sender_sensor_window_averager_top: FAILED **");
        $finish;
    end

endmodule
